@@ hdl/ct_pkg.sv @@
`timescale 1ns / 1ps

package ct_pkg;

  localparam int NumRes  = 27;
  localparam int StopIdx = 26;

  typedef logic [NumRes-1:0] res_set_t;
  typedef logic [6:0]        ascii_t;
  typedef logic [3:0]        nuc_t;
  typedef logic [4:0]        base_code_t;
  typedef logic [4:0]        res_idx_t;

  typedef struct packed {
    logic ok;
    nuc_t b1;
    nuc_t b2;
    nuc_t b3;
  } codon_t;

  localparam ascii_t CharX    = 7'h58;
  localparam ascii_t CharStop = 7'h2A;
  localparam ascii_t CharM    = 7'h4D;
  localparam ascii_t CharW    = 7'h57;
  localparam ascii_t CharB    = 7'h42;
  localparam ascii_t CharZ    = 7'h5A;
  localparam ascii_t CharA    = 7'h41;
  localparam ascii_t CharD    = 7'h44;
  localparam ascii_t CharN    = 7'h4E;
  localparam ascii_t CharE    = 7'h45;
  localparam ascii_t CharQ    = 7'h51;

  localparam logic [8*64-1:0] StdStr = {
    "KNKN", "IIMI", "RSRS", "TTTT",
    "*Y*Y", "LFLF", "*CWC", "SSSS",
    "EDED", "VVVV", "GGGG", "AAAA",
    "QHQH", "LLLL", "RRRR", "PPPP"
  };

  localparam logic [8*64-1:0] MitoStr = {
    "KNKN", "MIMI", "*S*S", "TTTT",
    "*Y*Y", "LFLF", "WCWC", "SSSS",
    "EDED", "VVVV", "GGGG", "AAAA",
    "QHQH", "LLLL", "RRRR", "PPPP"
  };

  function automatic res_idx_t res_index(input ascii_t c);
    if (c == CharStop) begin
      return res_idx_t'(StopIdx);
    end
    return res_idx_t'(c - CharA);
  endfunction

  function automatic ascii_t res_letter(input int idx);
    if (idx == StopIdx) begin
      return CharStop;
    end
    return ascii_t'(idx + int'(CharA));
  endfunction

endpackage

@@ hdl/codon_translator.sv @@
`timescale 1ns / 1ps

// Codon translator. Each input transaction carries three nucleotide codes
// (bit sets of A, T, G, C) and an action bit that asks for the reverse
// complement; the result transaction carries the ASCII amino-acid letter.
// Both channels use valid and stall; a transaction moves on a clock edge
// with valid high and stall low.
// The cfg_we/cfg_wdata port writes the genetic code select (0 standard,
// 1 mitochondrial). Write it only while no transaction is in flight.
// A transaction passes the input register, then the translation logic
// into the result register. One transaction is accepted every cycle as
// long as the receiver takes results; the input register keeps accepting
// while a finished result waits in the result register.
// When the receiver stalls, the result register holds its value, and once
// the input register is also full, in_stall goes high.
// Reset (rst_n low at a clock edge) empties both registers and selects
// the standard code.

module codon_translator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  ct_pkg::base_code_t in_first_base,
  input  ct_pkg::base_code_t in_second_base,
  input  ct_pkg::base_code_t in_third_base,
  output logic               out_valid,
  input  logic               out_stall,
  output ct_pkg::ascii_t     out_amino_acid
);
  import ct_pkg::*;

  logic       genetic_code_r, genetic_code_nxt;
  logic       s1_valid_r, s1_valid_nxt;
  logic       action_r;
  base_code_t first_r, second_r, third_r;
  logic       out_valid_r, out_valid_nxt;
  ascii_t     amino_r;
  logic       in_take;
  logic       s2_load;
  codon_t     codon;
  ascii_t     amino;

  assign s2_load  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s2_load;
  assign in_take  = in_valid && !in_stall;

  ct_prep u_prep (
    .action      (action_r),
    .first_base  (first_r),
    .second_base (second_r),
    .third_base  (third_r),
    .codon       (codon)
  );

  ct_lookup u_lookup (
    .genetic_code (genetic_code_r),
    .codon        (codon),
    .amino_acid   (amino)
  );

  always_comb begin
    genetic_code_nxt = cfg_we ? cfg_wdata : genetic_code_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_load) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (s2_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      genetic_code_r <= 1'b0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      genetic_code_r <= genetic_code_nxt;
      s1_valid_r     <= s1_valid_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      action_r <= in_action;
      first_r  <= in_first_base;
      second_r <= in_second_base;
      third_r  <= in_third_base;
    end
    if (s2_load) begin
      amino_r <= amino;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_amino_acid = amino_r;

endmodule

@@ hdl/ct_prep.sv @@
`timescale 1ns / 1ps

module ct_prep (
  input  logic                action,
  input  ct_pkg::base_code_t  first_base,
  input  ct_pkg::base_code_t  second_base,
  input  ct_pkg::base_code_t  third_base,
  output ct_pkg::codon_t      codon
);
  import ct_pkg::*;

  function automatic nuc_t comp(input nuc_t m);
    return {m[2], m[3], m[0], m[1]};
  endfunction

  function automatic logic code_ok(input base_code_t b);
    return (b != '0) && !b[4];
  endfunction

  nuc_t n1, n2, n3;

  assign n1 = first_base[3:0];
  assign n2 = second_base[3:0];
  assign n3 = third_base[3:0];

  always_comb begin
    codon.ok = code_ok(first_base) && code_ok(second_base) && code_ok(third_base);
    if (action) begin
      codon.b1 = comp(n3);
      codon.b2 = comp(n2);
      codon.b3 = comp(n1);
    end else begin
      codon.b1 = n1;
      codon.b2 = n2;
      codon.b3 = n3;
    end
  end

endmodule

@@ hdl/ct_lookup.sv @@
`timescale 1ns / 1ps

module ct_lookup (
  input  logic            genetic_code,
  input  ct_pkg::codon_t  codon,
  output ct_pkg::ascii_t  amino_acid
);
  import ct_pkg::*;

  res_set_t         present;
  res_set_t         dn_set;
  res_set_t         eq_set;
  logic             single;
  ascii_t           single_letter;
  logic [8*64-1:0]  tbl;

  assign tbl = genetic_code ? MitoStr : StdStr;

  // Each covered codon marks its residue in the presence set.
  always_comb begin
    present = '0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 4; k++) begin
          if (codon.b1[i] && codon.b2[j] && codon.b3[k]) begin
            present[res_index(tbl[8*(63-(i*16+j*4+k)) +: 7])] = 1'b1;
          end
        end
      end
    end
  end

  assign dn_set = (res_set_t'(1) << res_index(CharD)) | (res_set_t'(1) << res_index(CharN));
  assign eq_set = (res_set_t'(1) << res_index(CharE)) | (res_set_t'(1) << res_index(CharQ));
  assign single = (present != '0) && ((present & (present - res_set_t'(1))) == '0);

  always_comb begin
    single_letter = CharX;
    for (int r = 0; r < NumRes; r++) begin
      if (present[r]) begin
        single_letter = res_letter(r);
      end
    end
  end

  always_comb begin
    if (!codon.ok) begin
      amino_acid = CharX;
    end else if (single) begin
      amino_acid = single_letter;
    end else if (present == dn_set) begin
      amino_acid = CharB;
    end else if (present == eq_set) begin
      amino_acid = CharZ;
    end else begin
      amino_acid = CharX;
    end
  end

endmodule
